// File: design/wps_pkg.sv
// Package for the wheel pulse speedometer: field widths, register indexes,
// fixed-point constants and widths of the shared serial multiplier and divider.
// No dependencies; used by scoped name from the top level.
`default_nettype none

package wps_pkg;

	// Fixed-point format and period counter width
	localparam int SPEED_FRAC_BITS = 8;
	localparam int PERIOD_BITS     = 16;

	// Configuration register widths
	localparam int DIAM_W    = 10;
	localparam int MAG_W     = 3;
	localparam int TRIM_W    = 9;
	localparam int UPD_W     = 10;
	localparam int EASE_W    = 9;
	localparam int DECAY_W   = 13;
	localparam int SPEED_W   = 15;
	localparam int INACT_W   = 13;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 3;

	// Reset values of the configuration registers
	localparam logic [DIAM_W-1:0]  RST_DIAMETER = DIAM_W'(678);
	localparam logic [MAG_W-1:0]   RST_MAGNETS  = MAG_W'(2);
	localparam logic [TRIM_W-1:0]  RST_TRIM     = TRIM_W'(256);
	localparam logic [UPD_W-1:0]   RST_INTERVAL = UPD_W'(150);
	localparam logic [EASE_W-1:0]  RST_EASE     = EASE_W'(128);
	localparam logic [DECAY_W-1:0] RST_DECAY    = DECAY_W'(256);
	localparam logic [SPEED_W-1:0] RST_SPEED_MAX = SPEED_W'(15360);
	localparam logic [INACT_W-1:0] RST_INACTIVE = INACT_W'(2000);

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_DIAMETER = 3'd0,
		REG_MAGNET_COUNT   = 3'd1,
		REG_SPEED_TRIM     = 3'd2,
		REG_UPDATE_INTERVAL = 3'd3,
		REG_EASE_WEIGHT    = 3'd4,
		REG_DECAY_STEP     = 3'd5,
		REG_SPEED_MAXIMUM  = 3'd6,
		REG_INACTIVE_TIME  = 3'd7
	} cfg_reg_t;

	// Stream widths
	localparam int IN_W  = 8;
	localparam int OUT_W = 112;

	// Pi in millionths, and the scale of the mm-per-magnet divisor
	localparam int PI_MICRO  = 3141593;
	localparam int MAG_SCALE = 1000;
	localparam int MM_SCALE  = 1000;

	// Ease weight saturates at unity
	localparam logic [EASE_W-1:0] EASE_UNITY = EASE_W'(256);
	localparam int EASE_ROUND = 128;
	localparam int EASE_SHIFT = 8;

	// Timer limits
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};
	localparam logic [UPD_W-1:0]       UPD_MAX    = {UPD_W{1'b1}};

	// Speed register and clamp: 120 km/h fits in seven integer bits
	localparam int SPD_REG_W = 7 + SPEED_FRAC_BITS;
	localparam int SPEED_CAP = 120 << SPEED_FRAC_BITS;

	// Shift-add multiplier
	localparam int MUL_ACC_W   = 32;
	localparam int MUL_PLIER_W = 10;
	localparam int MUL_STEPS   = MUL_PLIER_W;

	// Pulse distance in micrometres, ride distance accumulator
	localparam int DIST_W   = 22;
	localparam int DISTUM_W = 42;
	localparam int MM_W     = 32;
	localparam int RIDE_T_W = 32;

	// Speed division: (dist*trim*36 << F + den/2) / (period * 2560000)
	localparam int DEN_SCALE   = 2560000;
	localparam int DEN_SCALE_W = 22;
	localparam int DEN_W       = PERIOD_BITS + DEN_SCALE_W;
	localparam int PROD_W      = 31;
	localparam int NUM_W       = PROD_W + 6 + SPEED_FRAC_BITS;
	localparam int DIV_A       = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
	localparam int DIV_W       = (DIV_A > DISTUM_W) ? DIV_A : DISTUM_W;
	localparam int CNT_W       = $clog2(DIV_W + 1);

endpackage : wps_pkg

`default_nettype wire

// File: design/wheel_pulse_speedometer_top.sv
// Wheel pulse speedometer: one sensor sample per millisecond tick in, one status item out.
// A shared shift-add multiplier and a restoring divider, one bit per cycle, do the arithmetic.
// Depends on wps_pkg.
// A tick without pulse runs ST_EASE, ST_FIN and ST_OUT; a pulse first runs the distance,
// speed and millimetre multiplies and divides, and an averaging update adds two multiplies.
// No new sample is taken until the last item is loaded for output; the bit-serial divider
// (32, DIV_W and 42 steps on a pulse) and the 10-step multiplier are the long states.
// Reset: arst_n clears all ride state and loads the default configuration.
`default_nettype none

module wheel_pulse_speedometer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave side: tdata = {7'b0, sensor_level}
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [wps_pkg::IN_W-1:0]       s_tdata,
	// master side: tdata from bit 0 up = pulse_seen, measured_speed[15], average_speed[15],
	// rider_active, ride_distance_mm[32], ride_top_speed[15], ride_time_ms[32], 1'b0
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [wps_pkg::OUT_W-1:0]           m_tdata,
	// configuration write port
	input  wire logic                           cfg_wen,
	input  wire logic [wps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wps_pkg::CFG_W-1:0]      cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_DMUL  = 11'b000_0000_0010,
		ST_DDIV  = 11'b000_0000_0100,
		ST_SMUL  = 11'b000_0000_1000,
		ST_SDIV  = 11'b000_0001_0000,
		ST_MDIV  = 11'b000_0010_0000,
		ST_EASE  = 11'b000_0100_0000,
		ST_EMUL1 = 11'b000_1000_0000,
		ST_EMUL2 = 11'b001_0000_0000,
		ST_FIN   = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	// Configuration registers
	logic [wps_pkg::DIAM_W-1:0]  diam_q;
	logic [wps_pkg::MAG_W-1:0]   mags_q;
	logic [wps_pkg::TRIM_W-1:0]  trim_q;
	logic [wps_pkg::UPD_W-1:0]   interval_q;
	logic [wps_pkg::EASE_W-1:0]  ease_q;
	logic [wps_pkg::DECAY_W-1:0] decay_q;
	logic [wps_pkg::SPEED_W-1:0] speed_max_q;
	logic [wps_pkg::INACT_W-1:0] inactive_q;

	// Ride state
	state_t                          state_q;
	logic                            prev_level_q;
	logic [wps_pkg::PERIOD_BITS-1:0] ms_q;
	logic [wps_pkg::UPD_W-1:0]       upd_q;
	logic [wps_pkg::SPD_REG_W-1:0]   meas_q;
	logic [wps_pkg::SPEED_W-1:0]     avg_q;
	logic                            active_q;
	logic [wps_pkg::DISTUM_W-1:0]    distance_q;
	logic [wps_pkg::MM_W-1:0]        mm_q;
	logic [wps_pkg::SPEED_W-1:0]     top_q;
	logic [wps_pkg::RIDE_T_W-1:0]    ride_timer_q;
	logic                            pulse_q;
	logic                            out_valid_q;
	logic [wps_pkg::OUT_W-1:0]       out_data_q;

	// Shared serial arithmetic
	logic [wps_pkg::MUL_ACC_W-1:0]   mul_acc_q;
	logic [wps_pkg::MUL_ACC_W-1:0]   mul_cand_q;
	logic [wps_pkg::MUL_PLIER_W-1:0] mul_plier_q;
	logic [wps_pkg::DIV_W-1:0]       div_q_q;
	logic [wps_pkg::DEN_W-1:0]       div_r_q;
	logic [wps_pkg::DEN_W-1:0]       div_d_q;
	logic [wps_pkg::CNT_W-1:0]       cnt_q;
	logic [wps_pkg::PERIOD_BITS-1:0] period_q;
	logic [wps_pkg::DEN_W-1:0]       den_q;

	// Combinational helpers
	logic                            accept;
	logic                            out_fire;
	logic                            level;
	logic                            edge_det;
	logic [wps_pkg::PERIOD_BITS-1:0] ms_inc;
	logic                            cnt_zero;
	logic [wps_pkg::MUL_ACC_W-1:0]   mul_sum;
	logic [wps_pkg::DEN_W:0]         div_r2;
	logic                            div_ge;
	logic [wps_pkg::DEN_W-1:0]       div_r_nx;
	logic [wps_pkg::DIV_W-1:0]       spd_dividend;
	logic [wps_pkg::PERIOD_BITS-1:0] period_eff;
	logic [wps_pkg::MAG_W-1:0]       mags_eff;
	logic [wps_pkg::EASE_W-1:0]      w_eff;
	logic [wps_pkg::DISTUM_W:0]      dist_sum;
	logic [wps_pkg::MUL_ACC_W-1:0]   ease_sum;
	logic [wps_pkg::MUL_ACC_W-wps_pkg::EASE_SHIFT-1:0] ease_full;
	logic [wps_pkg::SPEED_W-1:0]     ease_clamped;

	// Handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_fire = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Edge detection and timer increment
	assign level    = s_tdata[0];
	assign edge_det = prev_level_q && !level;
	assign ms_inc   = (ms_q != wps_pkg::PERIOD_MAX) ? ms_q + wps_pkg::PERIOD_BITS'(1) : ms_q;

	// Serial multiplier and divider step logic
	always_comb begin
		cnt_zero   = (cnt_q == '0);
		mul_sum    = mul_acc_q + (mul_plier_q[0] ? mul_cand_q : '0);
		div_r2     = {div_r_q, div_q_q[wps_pkg::DIV_W-1]};
		div_ge     = (div_r2 >= {1'b0, div_d_q});
		div_r_nx   = div_ge ? wps_pkg::DEN_W'(div_r2 - {1'b0, div_d_q})
		                    : div_r2[wps_pkg::DEN_W-1:0];
		spd_dividend = (wps_pkg::DIV_W'(mul_acc_q) << (5 + wps_pkg::SPEED_FRAC_BITS))
		             + (wps_pkg::DIV_W'(mul_acc_q) << (2 + wps_pkg::SPEED_FRAC_BITS))
		             + wps_pkg::DIV_W'(den_q >> 1);
		period_eff = (period_q == '0) ? wps_pkg::PERIOD_BITS'(1) : period_q;
		mags_eff   = (mags_q == '0) ? wps_pkg::MAG_W'(1) : mags_q;
		w_eff      = (ease_q > wps_pkg::EASE_UNITY) ? wps_pkg::EASE_UNITY : ease_q;
		dist_sum   = {1'b0, distance_q}
		           + (wps_pkg::DISTUM_W + 1)'(div_q_q[wps_pkg::DIST_W-1:0]);
		ease_sum   = mul_acc_q + wps_pkg::MUL_ACC_W'(wps_pkg::EASE_ROUND);
		ease_full  = ease_sum[wps_pkg::MUL_ACC_W-1:wps_pkg::EASE_SHIFT];
		ease_clamped = (ease_full > (wps_pkg::MUL_ACC_W - wps_pkg::EASE_SHIFT)'(speed_max_q))
		             ? speed_max_q : ease_full[wps_pkg::SPEED_W-1:0];
	end

	// Control, configuration and ride state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q       <= wps_pkg::RST_DIAMETER;
			mags_q       <= wps_pkg::RST_MAGNETS;
			trim_q       <= wps_pkg::RST_TRIM;
			interval_q   <= wps_pkg::RST_INTERVAL;
			ease_q       <= wps_pkg::RST_EASE;
			decay_q      <= wps_pkg::RST_DECAY;
			speed_max_q  <= wps_pkg::RST_SPEED_MAX;
			inactive_q   <= wps_pkg::RST_INACTIVE;
			state_q      <= ST_IDLE;
			prev_level_q <= 1'b0;
			ms_q         <= '0;
			upd_q        <= '0;
			meas_q       <= '0;
			avg_q        <= '0;
			active_q     <= 1'b0;
			distance_q   <= '0;
			mm_q         <= '0;
			top_q        <= '0;
			ride_timer_q <= '0;
			pulse_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Register writes
			if (cfg_wen) begin
				unique case (wps_pkg::cfg_reg_t'(cfg_index))
					wps_pkg::REG_WHEEL_DIAMETER:  diam_q      <= cfg_data[wps_pkg::DIAM_W-1:0];
					wps_pkg::REG_MAGNET_COUNT:    mags_q      <= cfg_data[wps_pkg::MAG_W-1:0];
					wps_pkg::REG_SPEED_TRIM:      trim_q      <= cfg_data[wps_pkg::TRIM_W-1:0];
					wps_pkg::REG_UPDATE_INTERVAL: interval_q  <= cfg_data[wps_pkg::UPD_W-1:0];
					wps_pkg::REG_EASE_WEIGHT:     ease_q      <= cfg_data[wps_pkg::EASE_W-1:0];
					wps_pkg::REG_DECAY_STEP:      decay_q     <= cfg_data[wps_pkg::DECAY_W-1:0];
					wps_pkg::REG_SPEED_MAXIMUM:   speed_max_q <= cfg_data[wps_pkg::SPEED_W-1:0];
					wps_pkg::REG_INACTIVE_TIME:   inactive_q  <= cfg_data[wps_pkg::INACT_W-1:0];
					default: ;
				endcase
			end

			// Raise valid on a new output item, drop it once taken
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Advance timers, then detect the falling edge
						upd_q <= (upd_q != wps_pkg::UPD_MAX) ? upd_q + wps_pkg::UPD_W'(1) : upd_q;
						if (active_q && (ride_timer_q != '1)) begin
							ride_timer_q <= ride_timer_q + wps_pkg::RIDE_T_W'(1);
						end
						prev_level_q <= level;
						pulse_q      <= edge_det;
						ms_q         <= edge_det ? '0 : ms_inc;
						if (edge_det && !active_q) begin
							active_q     <= 1'b1;
							distance_q   <= '0;
							mm_q         <= '0;
							top_q        <= '0;
							ride_timer_q <= '0;
						end
						state_q <= edge_det ? ST_DMUL : ST_EASE;
					end
				end
				ST_DMUL: begin
					if (cnt_zero) begin
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: begin
					// Add the pulse distance, saturating
					if (cnt_zero) begin
						distance_q <= dist_sum[wps_pkg::DISTUM_W] ? '1
						            : dist_sum[wps_pkg::DISTUM_W-1:0];
						state_q    <= ST_SMUL;
					end
				end
				ST_SMUL: begin
					if (cnt_zero) begin
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					// Clamp the measured speed to the cap
					if (cnt_zero) begin
						meas_q  <= (div_q_q > wps_pkg::DIV_W'(wps_pkg::SPEED_CAP))
						         ? wps_pkg::SPD_REG_W'(wps_pkg::SPEED_CAP)
						         : div_q_q[wps_pkg::SPD_REG_W-1:0];
						state_q <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					// Millimetres, saturating at 32 bits
					if (cnt_zero) begin
						mm_q    <= (|div_q_q[wps_pkg::DISTUM_W-1:wps_pkg::MM_W]) ? '1
						         : div_q_q[wps_pkg::MM_W-1:0];
						state_q <= ST_EASE;
					end
				end
				ST_EASE: begin
					state_q <= (upd_q > interval_q) ? ST_EMUL1 : ST_FIN;
				end
				ST_EMUL1: begin
					if (cnt_zero) begin
						state_q <= ST_EMUL2;
					end
				end
				ST_EMUL2: begin
					// Take the eased speed and follow it with the top speed
					if (cnt_zero) begin
						avg_q <= ease_clamped;
						if (active_q && (ease_clamped > top_q)) begin
							top_q <= ease_clamped;
						end
						upd_q   <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Decay while idle, end the ride once speed is zero
					if ((ms_q > wps_pkg::PERIOD_BITS'(inactive_q)) && active_q) begin
						if (meas_q != '0) begin
							meas_q <= (32'(meas_q) > 32'(decay_q))
							        ? meas_q - wps_pkg::SPD_REG_W'(decay_q) : '0;
						end else begin
							active_q     <= 1'b0;
							avg_q        <= '0;
							meas_q       <= '0;
							distance_q   <= '0;
							mm_q         <= '0;
							top_q        <= '0;
							ride_timer_q <= '0;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath of the shared multiplier and divider, and the output item
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// Load diameter times pi
				if (accept) begin
					period_q    <= ms_inc;
					mul_acc_q   <= '0;
					mul_cand_q  <= wps_pkg::MUL_ACC_W'(wps_pkg::PI_MICRO);
					mul_plier_q <= wps_pkg::MUL_PLIER_W'(diam_q);
					cnt_q       <= wps_pkg::CNT_W'(wps_pkg::MUL_STEPS);
				end
			end
			ST_DMUL: begin
				den_q <= wps_pkg::DEN_W'(period_eff) * wps_pkg::DEN_W'(wps_pkg::DEN_SCALE);
				if (!cnt_zero) begin
					mul_acc_q   <= mul_sum;
					mul_cand_q  <= mul_cand_q << 1;
					mul_plier_q <= mul_plier_q >> 1;
					cnt_q       <= cnt_q - wps_pkg::CNT_W'(1);
				end else begin
					// Divide by magnets times 1000
					div_q_q <= wps_pkg::DIV_W'(mul_acc_q) << (wps_pkg::DIV_W - wps_pkg::MUL_ACC_W);
					div_r_q <= '0;
					div_d_q <= wps_pkg::DEN_W'(mags_eff) * wps_pkg::DEN_W'(wps_pkg::MAG_SCALE);
					cnt_q   <= wps_pkg::CNT_W'(wps_pkg::MUL_ACC_W);
				end
			end
			ST_DDIV: begin
				if (!cnt_zero) begin
					div_q_q <= {div_q_q[wps_pkg::DIV_W-2:0], div_ge};
					div_r_q <= div_r_nx;
					cnt_q   <= cnt_q - wps_pkg::CNT_W'(1);
				end else begin
					// Pulse distance times trim
					mul_acc_q   <= '0;
					mul_cand_q  <= wps_pkg::MUL_ACC_W'(div_q_q[wps_pkg::DIST_W-1:0]);
					mul_plier_q <= wps_pkg::MUL_PLIER_W'(trim_q);
					cnt_q       <= wps_pkg::CNT_W'(wps_pkg::MUL_STEPS);
				end
			end
			ST_SMUL: begin
				if (!cnt_zero) begin
					mul_acc_q   <= mul_sum;
					mul_cand_q  <= mul_cand_q << 1;
					mul_plier_q <= mul_plier_q >> 1;
					cnt_q       <= cnt_q - wps_pkg::CNT_W'(1);
				end else begin
					// Rounded speed quotient over the scaled period
					div_q_q <= spd_dividend;
					div_r_q <= '0;
					div_d_q <= den_q;
					cnt_q   <= wps_pkg::CNT_W'(wps_pkg::DIV_W);
				end
			end
			ST_SDIV: begin
				if (!cnt_zero) begin
					div_q_q <= {div_q_q[wps_pkg::DIV_W-2:0], div_ge};
					div_r_q <= div_r_nx;
					cnt_q   <= cnt_q - wps_pkg::CNT_W'(1);
				end else begin
					// Ride distance to millimetres
					div_q_q <= wps_pkg::DIV_W'(distance_q) << (wps_pkg::DIV_W - wps_pkg::DISTUM_W);
					div_r_q <= '0;
					div_d_q <= wps_pkg::DEN_W'(wps_pkg::MM_SCALE);
					cnt_q   <= wps_pkg::CNT_W'(wps_pkg::DISTUM_W);
				end
			end
			ST_MDIV: begin
				if (!cnt_zero) begin
					div_q_q <= {div_q_q[wps_pkg::DIV_W-2:0], div_ge};
					div_r_q <= div_r_nx;
					cnt_q   <= cnt_q - wps_pkg::CNT_W'(1);
				end
			end
			ST_EASE: begin
				// Averaged speed times the complement weight
				mul_acc_q   <= '0;
				mul_cand_q  <= wps_pkg::MUL_ACC_W'(avg_q);
				mul_plier_q <= wps_pkg::MUL_PLIER_W'(wps_pkg::EASE_UNITY - w_eff);
				cnt_q       <= wps_pkg::CNT_W'(wps_pkg::MUL_STEPS);
			end
			ST_EMUL1: begin
				if (!cnt_zero) begin
					mul_acc_q   <= mul_sum;
					mul_cand_q  <= mul_cand_q << 1;
					mul_plier_q <= mul_plier_q >> 1;
					cnt_q       <= cnt_q - wps_pkg::CNT_W'(1);
				end else begin
					// Accumulate measured speed times weight
					mul_cand_q  <= wps_pkg::MUL_ACC_W'(meas_q);
					mul_plier_q <= wps_pkg::MUL_PLIER_W'(w_eff);
					cnt_q       <= wps_pkg::CNT_W'(wps_pkg::MUL_STEPS);
				end
			end
			ST_EMUL2: begin
				if (!cnt_zero) begin
					mul_acc_q   <= mul_sum;
					mul_cand_q  <= mul_cand_q << 1;
					mul_plier_q <= mul_plier_q >> 1;
					cnt_q       <= cnt_q - wps_pkg::CNT_W'(1);
				end
			end
			ST_FIN: ;
			ST_OUT: begin
				// Pack the result item
				if (out_fire) begin
					out_data_q <= wps_pkg::OUT_W'({ride_timer_q, top_q, mm_q, active_q, avg_q,
					                               wps_pkg::SPEED_W'(meas_q), pulse_q});
				end
			end
			default: ;
		endcase
	end

	// Accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("block idle right after accepting an item");

	// Ride fields stay cleared while no ride is active
	a_ride_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> ((distance_q == '0) && (mm_q == '0) && (top_q == '0)
		               && (ride_timer_q == '0)))
		else $error("ride fields not cleared while inactive");

	// Measured speed never exceeds the cap
	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		meas_q <= wps_pkg::SPD_REG_W'(wps_pkg::SPEED_CAP))
		else $error("measured speed above cap");

endmodule : wheel_pulse_speedometer_top

`default_nettype wire
